// ===== src/sga_pkg.sv =====
// Shared types and constants for the score group aggregator.
// Used by sga_alu and score_group_aggregator_core; depends on nothing.
`default_nettype none

package sga_pkg;

   localparam int ACC_W      = 24;
   localparam int SCORE_W    = 17;
   localparam int OUT_W      = 23;
   localparam int PROD_W     = ACC_W + SCORE_W;
   localparam int DIV_CNT_W  = 5;

   localparam logic [ACC_W-1:0]   ONE_Q16   = 24'd65536;
   localparam logic [ACC_W-1:0]   OUT_MAX   = 24'h3FFFFF;
   localparam logic [ACC_W:0]     OUT_MIN   = 25'h1C00000;
   localparam logic [OUT_W-1:0]   OUT_MIN_R = 23'h400000;
   localparam logic [SCORE_W-1:0] SCORE_ONE = 17'd65536;

   // Reduction modes held in the eval_mode register; unlisted codes sum.
   localparam logic [2:0] MODE_SUM  = 3'd0;
   localparam logic [2:0] MODE_MIN  = 3'd1;
   localparam logic [2:0] MODE_MAX  = 3'd2;
   localparam logic [2:0] MODE_MEAN = 3'd3;
   localparam logic [2:0] MODE_PROD = 3'd4;
   localparam logic [2:0] MODE_FNZ  = 3'd5;

   // Register indexes of the configuration port.
   localparam logic CSR_EVAL_MODE = 1'b0;
   localparam logic CSR_INVERT    = 1'b1;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ACC_W-1:0] a;
      logic [ACC_W-1:0] b;
   } alu_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_APPLY,
      ST_FINISH,
      ST_DIV,
      ST_INV,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

// ===== src/sga_alu.sv =====
// Shared arithmetic unit: add, two's complement subtract or multiply.
// Depends on sga_pkg for the request struct and widths.
`default_nettype none

module sga_alu (
   input  wire sga_pkg::alu_req_type          req,
   output logic [sga_pkg::PROD_W-1:0]         res
);

   logic [sga_pkg::ACC_W:0] sum;
   logic [sga_pkg::ACC_W:0] diff;

   // Both sums are one bit wider; for the subtract that bit is the sign.
   assign sum  = {1'b0, req.a} + {1'b0, req.b};
   assign diff = {1'b0, req.a} - {1'b0, req.b};

   always_comb begin
      unique case (req.op)
         sga_pkg::ALU_ADD: res = {{(sga_pkg::PROD_W-sga_pkg::ACC_W-1){1'b0}}, sum};
         sga_pkg::ALU_SUB: res = {{(sga_pkg::PROD_W-sga_pkg::ACC_W-1){1'b0}}, diff};
         sga_pkg::ALU_MUL: res = {{(sga_pkg::PROD_W-sga_pkg::ACC_W){1'b0}}, req.a}
                                 * {{(sga_pkg::PROD_W-sga_pkg::SCORE_W){1'b0}},
                                    req.b[sga_pkg::SCORE_W-1:0]};
         default:          res = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/score_group_aggregator_core.sv =====
// Top level of the score group aggregator: sequencer, group state and channels.
// Depends on sga_pkg and instantiates the shared arithmetic unit sga_alu.
`default_nettype none

//  Channel   Direction  Handshake            Payload
//  req_      in         tvalid/tready        tdata: item_score; tuser: counted,
//                                            child_veto, empty_group; tlast: last_child
//  rsp_      out        tvalid/tready        tdata: group_score; tuser: group_vetoed
//  csr_      in         wen (no wait)        index, wdata: eval_mode, invert_result
//
//  A child item passes through accept, one pass through the shared unit and update.
//  An empty-group item passes through accept, check and hand-over.
//  The last item of a group adds finish, inversion and hand-over (no inversion when
//  the group settled early); the mean also runs a restoring division on the same
//  shared unit, whose quotient is formed one bit a cycle.
//  A finished result waits in the output register; the next item may be accepted
//  meanwhile, and the sequencer only stalls when a second result finds it full.
//  Reset is synchronous and active high; it clears the group and sets eval_mode
//  to product and invert_result to zero.

module score_group_aggregator_core #(
   parameter int MAX_CHILDREN = 64
) (
   input  wire         clock,
   input  wire         reset,
   // Input item channel.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // [16:0] item_score, [23:17] zero fill
   input  wire  [2:0]  req_tuser,   // [0] counted, [1] child_veto, [2] empty_group
   input  wire         req_tlast,   // last_child
   // Result channel.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [22:0] group_score, [23] zero fill
   output logic        rsp_tuser,   // [0] group_vetoed
   // Configuration writes.
   input  wire         csr_wen,
   input  wire         csr_index,
   input  wire  [2:0]  csr_wdata
);

   localparam int POS_W = $clog2(MAX_CHILDREN + 1);
   localparam int ACC_W = sga_pkg::ACC_W;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHILDREN);
   // The running sum and product saturate at the lesser of MAX_CHILDREN * 1.0
   // and the accumulator's full scale.
   localparam longint CAP_FULL = longint'(MAX_CHILDREN) * 65536;
   localparam logic [ACC_W-1:0] SUM_CAP =
      (CAP_FULL > 64'hFFFFFF) ? 24'hFFFFFF : ACC_W'(CAP_FULL);

   sga_pkg::state_type state_ff, state_in;

   logic [2:0]                    mode_ff, mode_in;
   logic                          inv_ff, inv_in;
   logic [ACC_W-1:0]              acc_ff, acc_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic                          fin_ff, fin_in;
   logic [sga_pkg::SCORE_W-1:0]   early_val_ff, early_val_in;
   logic                          early_veto_ff, early_veto_in;
   logic [ACC_W-1:0]              rem_ff, rem_in;
   logic [sga_pkg::DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // Latched item and intermediate results; these need no reset.
   logic [sga_pkg::SCORE_W-1:0]   score_ff, score_in;
   logic                          cnt_ff, cnt_in;
   logic                          veto_ff, veto_in;
   logic                          last_ff, last_in;
   logic                          empty_ff, empty_in;
   logic [sga_pkg::PROD_W-1:0]    alu_ff, alu_in;
   logic [sga_pkg::OUT_W-1:0]     res_score_ff, res_score_in;
   logic                          res_veto_ff, res_veto_in;
   logic [sga_pkg::OUT_W-1:0]     rsp_score_ff, rsp_score_in;
   logic                          rsp_veto_ff, rsp_veto_in;

   sga_pkg::alu_req_type          alu_req;
   logic [sga_pkg::PROD_W-1:0]    alu_res;

   logic [ACC_W-1:0]              score_ext;
   logic [ACC_W-1:0]              trial;
   logic [ACC_W-1:0]              prod_new;
   logic [ACC_W:0]                prod_hi;
   logic                          first;

   sga_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W:0] v);
      logic [ACC_W-1:0] r;
      if (v > {1'b0, SUM_CAP}) begin
         r = SUM_CAP;
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

   assign score_ext  = {{(ACC_W-sga_pkg::SCORE_W){1'b0}}, score_ff};
   assign first      = (pos_ff == '0);
   assign prod_hi    = alu_ff[sga_pkg::PROD_W-1:16];
   assign prod_new   = first ? score_ext : sat_acc(prod_hi);
   // Next partial remainder of the restoring division: bring down one dividend bit.
   assign trial      = {rem_ff[ACC_W-2:0], acc_ff[ACC_W-1]};

   assign req_tready = (state_ff == sga_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_score_ff};
   assign rsp_tuser  = rsp_veto_ff;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      inv_in        = inv_ff;
      acc_in        = acc_ff;
      pos_in        = pos_ff;
      fin_in        = fin_ff;
      early_val_in  = early_val_ff;
      early_veto_in = early_veto_ff;
      rem_in        = rem_ff;
      dcnt_in       = dcnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      score_in      = score_ff;
      cnt_in        = cnt_ff;
      veto_in       = veto_ff;
      last_in       = last_ff;
      empty_in      = empty_ff;
      alu_in        = alu_ff;
      res_score_in  = res_score_ff;
      res_veto_in   = res_veto_ff;
      rsp_score_in  = rsp_score_ff;
      rsp_veto_in   = rsp_veto_ff;
      alu_req.op    = sga_pkg::ALU_ADD;
      alu_req.a     = acc_ff;
      alu_req.b     = score_ext;

      // Configuration must be written only while the block is idle; the block does not enforce it.
      if (csr_wen) begin
         unique case (csr_index)
            sga_pkg::CSR_EVAL_MODE: mode_in = csr_wdata;
            sga_pkg::CSR_INVERT:    inv_in  = csr_wdata[0];
            default:                mode_in = mode_ff;
         endcase
      end

      // A result leaves the output register on its transfer.
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         sga_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               // Scores above 1.0 are taken as 1.0.
               score_in = (req_tdata[16:0] > sga_pkg::SCORE_ONE) ? sga_pkg::SCORE_ONE
                                                               : req_tdata[16:0];
               cnt_in   = req_tuser[0];
               veto_in  = req_tuser[1];
               empty_in = req_tuser[2];
               last_in  = req_tlast;
               state_in = sga_pkg::ST_UPDATE;
            end
         end

         sga_pkg::ST_UPDATE: begin
            if (empty_ff) begin
               // An empty group answers zero at once, never inverted.
               res_score_in = '0;
               res_veto_in  = 1'b0;
               state_in     = sga_pkg::ST_RESULT;
            end else begin
               unique case (mode_ff)
                  sga_pkg::MODE_MIN, sga_pkg::MODE_MAX: begin
                     alu_req.op = sga_pkg::ALU_SUB;
                  end
                  sga_pkg::MODE_PROD: begin
                     alu_req.op = sga_pkg::ALU_MUL;
                  end
                  sga_pkg::MODE_FNZ: begin
                     alu_req.op = sga_pkg::ALU_SUB;
                     alu_req.a  = sga_pkg::ONE_Q16;
                  end
                  default: begin
                     alu_req.op = sga_pkg::ALU_ADD;
                  end
               endcase
               alu_in   = alu_res;
               state_in = sga_pkg::ST_APPLY;
            end
         end

         sga_pkg::ST_APPLY: begin
            if (!fin_ff && cnt_ff) begin
               if (veto_ff) begin
                  fin_in        = 1'b1;
                  early_val_in  = '0;
                  early_veto_in = 1'b1;
               end else begin
                  unique case (mode_ff)
                     sga_pkg::MODE_MIN: begin
                        // The score is below the accumulator when acc - score > 0.
                        if (first || (!alu_ff[ACC_W] && alu_ff[ACC_W-1:0] != '0)) begin
                           acc_in = score_ext;
                        end
                     end
                     sga_pkg::MODE_MAX: begin
                        if (first || alu_ff[ACC_W]) begin
                           acc_in = score_ext;
                        end
                     end
                     sga_pkg::MODE_PROD: begin
                        acc_in = prod_new;
                        if (prod_new == '0) begin
                           fin_in        = 1'b1;
                           early_val_in  = inv_ff ? sga_pkg::SCORE_ONE : '0;
                           early_veto_in = 1'b0;
                        end
                     end
                     sga_pkg::MODE_FNZ: begin
                        if (score_ff != '0) begin
                           fin_in        = 1'b1;
                           early_val_in  = inv_ff ? alu_ff[sga_pkg::SCORE_W-1:0] : score_ff;
                           early_veto_in = 1'b0;
                        end
                     end
                     default: begin
                        acc_in = sat_acc(alu_ff[ACC_W:0]);
                     end
                  endcase
               end
            end
            // Skipped children advance the position as well.
            if (pos_ff < POS_MAX) begin
               pos_in = pos_ff + POS_W'(1);
            end
            state_in = last_ff ? sga_pkg::ST_FINISH : sga_pkg::ST_IDLE;
         end

         sga_pkg::ST_FINISH: begin
            if (fin_ff) begin
               res_score_in = {{(sga_pkg::OUT_W-sga_pkg::SCORE_W){1'b0}}, early_val_ff};
               res_veto_in  = early_veto_ff;
               state_in     = sga_pkg::ST_RESULT;
            end else if (mode_ff == sga_pkg::MODE_MEAN && pos_ff != '0) begin
               rem_in   = '0;
               dcnt_in  = '0;
               state_in = sga_pkg::ST_DIV;
            end else begin
               state_in = sga_pkg::ST_INV;
            end
         end

         sga_pkg::ST_DIV: begin
            // One quotient bit per cycle; the accumulator shifts the dividend out
            // and the quotient in.
            alu_req.op = sga_pkg::ALU_SUB;
            alu_req.a  = trial;
            alu_req.b  = {{(ACC_W-POS_W){1'b0}}, pos_ff};
            if (!alu_res[ACC_W]) begin
               rem_in = alu_res[ACC_W-1:0];
               acc_in = {acc_ff[ACC_W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               acc_in = {acc_ff[ACC_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + sga_pkg::DIV_CNT_W'(1);
            if (dcnt_ff == sga_pkg::DIV_CNT_W'(ACC_W - 1)) begin
               state_in = sga_pkg::ST_INV;
            end
         end

         sga_pkg::ST_INV: begin
            res_veto_in = 1'b0;
            if (inv_ff) begin
               alu_req.op = sga_pkg::ALU_SUB;
               alu_req.a  = sga_pkg::ONE_Q16;
               alu_req.b  = acc_ff;
               if ($signed(alu_res[ACC_W:0]) < $signed(sga_pkg::OUT_MIN)) begin
                  res_score_in = sga_pkg::OUT_MIN_R;
               end else begin
                  res_score_in = alu_res[sga_pkg::OUT_W-1:0];
               end
            end else begin
               if (acc_ff > sga_pkg::OUT_MAX) begin
                  res_score_in = sga_pkg::OUT_MAX[sga_pkg::OUT_W-1:0];
               end else begin
                  res_score_in = acc_ff[sga_pkg::OUT_W-1:0];
               end
            end
            state_in = sga_pkg::ST_RESULT;
         end

         sga_pkg::ST_RESULT: begin
            // Hand the result over once the output register is free, and
            // start a fresh group.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_score_in  = res_score_ff;
               rsp_veto_in   = res_veto_ff;
               acc_in        = '0;
               pos_in        = '0;
               fin_in        = 1'b0;
               early_val_in  = '0;
               early_veto_in = 1'b0;
               state_in      = sga_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sga_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sga_pkg::ST_IDLE;
         mode_ff       <= sga_pkg::MODE_PROD;
         inv_ff        <= 1'b0;
         acc_ff        <= '0;
         pos_ff        <= '0;
         fin_ff        <= 1'b0;
         early_val_ff  <= '0;
         early_veto_ff <= 1'b0;
         rem_ff        <= '0;
         dcnt_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         inv_ff        <= inv_in;
         acc_ff        <= acc_in;
         pos_ff        <= pos_in;
         fin_ff        <= fin_in;
         early_val_ff  <= early_val_in;
         early_veto_ff <= early_veto_in;
         rem_ff        <= rem_in;
         dcnt_ff       <= dcnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      score_ff     <= score_in;
      cnt_ff       <= cnt_in;
      veto_ff      <= veto_in;
      last_ff      <= last_in;
      empty_ff     <= empty_in;
      alu_ff       <= alu_in;
      res_score_ff <= res_score_in;
      res_veto_ff  <= res_veto_in;
      rsp_score_ff <= rsp_score_in;
      rsp_veto_ff  <= rsp_veto_in;
   end

   // An accepted item keeps the sequencer busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted twice in a row");

   // A vetoed group always reports a zero score.
   a_veto_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("vetoed result with nonzero score");

   // The position count never passes its saturation point.
   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_MAX)
      else $error("child position beyond MAX_CHILDREN");

   // The division only runs for a mean group that did not settle early.
   a_div_mean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sga_pkg::ST_DIV) |-> (!fin_ff && mode_ff == sga_pkg::MODE_MEAN
                                         && pos_ff != '0))
      else $error("division started outside a mean group");

endmodule

`default_nettype wire

// ===== test/tb_score_group_aggregator_core.sv =====
// Self-checking testbench for score_group_aggregator_core: drives child scores
// with random gaps and stalls and checks every group score against a predictor.
// Depends on sga_pkg and the score_group_aggregator_core RTL only.
`timescale 1ns / 1ps

module tb_score_group_aggregator_core;

   localparam int MAX_CHILDREN = 64;

   // The mean's serial divide is the slowest path through a group, so this many
   // quiet cycles means the block has settled.
   localparam int SETTLE_CYCLES = 40;

   // The accumulator saturates at the lesser of MAX_CHILDREN ones and 24 bits.
   localparam longint unsigned ACC_CAP =
      (longint'(MAX_CHILDREN) * 65536 > 64'hFFFFFF) ? 64'hFFFFFF
                                                    : longint'(MAX_CHILDREN) * 65536;
   localparam longint SCORE_HI = 4194303;
   localparam longint SCORE_LO = -4194304;

   // Flavors of random child scores; low scores make products truncate to zero.
   typedef enum int {
      SCORES_ANY,
      SCORES_HIGH,
      SCORES_LOW
   } score_mix_type;

   typedef struct packed {
      logic [22:0] score;
      logic        vetoed;
   } group_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [16:0] item_score, [23:17] zero fill
   logic [2:0]  req_tuser = '0;   // [0] counted, [1] child_veto, [2] empty_group
   logic        req_tlast = 1'b0; // last_child
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [22:0] group_score, [23] zero fill
   logic        rsp_tuser;        // [0] group_vetoed
   logic        csr_wen = 1'b0;
   logic        csr_index = 1'b0;
   logic [2:0]  csr_wdata = '0;

   // Group results that the predictor has worked out and the block still owes.
   group_result_type group_results_q[$];
   int               err_count = 0;

   // Predictor copy of the configuration registers and the group state.
   logic [2:0]  mode_reg = sga_pkg::MODE_PROD;
   logic        invert_reg = 1'b0;
   logic [23:0] acc = '0;
   int          position = 0;
   bit          settled = 1'b0;
   logic [16:0] settled_score = '0;
   bit          settled_veto = 1'b0;

   // Sender pacing: bursts of random length separated by random gaps, unless
   // a test asks for a steady stream.
   int burst_left = 0;
   bit steady_sender = 1'b0;

   // Receiver pacing: an 8-bit ready pattern that is replaced when its random age
   // runs out; some patterns are all ones, so there are stretches without stalls.
   logic [7:0] ready_pattern = 8'hFF;
   int         pattern_age = 0;

   score_group_aggregator_core #(
      .MAX_CHILDREN(MAX_CHILDREN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // The run ends here if the block stops making progress.
   initial begin
      #10_000_000;
      $display("tb_score_group_aggregator_core: errors");
      $finish;
   end

   always @(posedge clock) begin
      if (pattern_age == 0) begin
         pattern_age = $urandom_range(16, 96);
         case ($urandom_range(0, 3))
            0: ready_pattern = 8'hFF;
            1: ready_pattern = 8'($urandom_range(0, 255));
            default: ready_pattern = 8'($urandom_range(0, 255)) | 8'h11;
         endcase
      end
      pattern_age = pattern_age - 1;
      rsp_tready <= ready_pattern[3'(pattern_age % 8)];
   end

   // Each result transfer is compared with the oldest owed result. Outputs are
   // read at the clock edge, before the block's own updates of that edge land.
   always @(posedge clock) begin
      group_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (group_results_q.size() == 0) begin
            $error("group_score: no result expected, got %0d",
                   $signed(rsp_tdata[22:0]));
            err_count++;
         end else begin
            want = group_results_q.pop_front();
            if (rsp_tdata[22:0] !== want.score) begin
               $error("group_score: expected %0d, got %0d",
                      $signed(want.score), $signed(rsp_tdata[22:0]));
               err_count++;
            end
            if (rsp_tuser !== want.vetoed) begin
               $error("group_vetoed: expected %0d, got %0d", want.vetoed, rsp_tuser);
               err_count++;
            end
         end
      end
   end

   function automatic logic [23:0] cap_acc(input longint unsigned raw);
      return (raw > ACC_CAP) ? ACC_CAP[23:0] : raw[23:0];
   endfunction

   task automatic clear_group_state();
      acc = '0;
      position = 0;
      settled = 1'b0;
      settled_score = '0;
      settled_veto = 1'b0;
   endtask

   // A group that has settled early keeps its answer until its last child.
   task automatic settle_group(input logic [16:0] score, input bit veto);
      settled = 1'b1;
      settled_score = score;
      settled_veto = veto;
   endtask

   // Folds one accepted child into the predicted group state and, at the end
   // of a group or on an empty group, queues the result the block owes.
   task automatic fold_child(input logic [16:0] raw, input bit counted, input bit veto,
                             input bit last, input bit empty);
      logic [16:0]      s;
      bit               first;
      longint unsigned  wide;
      longint           v;
      group_result_type r;
      s = (raw > sga_pkg::SCORE_ONE) ? sga_pkg::SCORE_ONE : raw;
      if (empty) begin
         // An empty group answers zero at once, invert or not.
         r.score = '0;
         r.vetoed = 1'b0;
         group_results_q.push_back(r);
         clear_group_state();
      end else begin
         if (!settled && counted) begin
            // Min, max and product seed only from position zero, so a skipped
            // first child leaves them starting from zero.
            first = (position == 0);
            if (veto) begin
               settle_group(17'd0, 1'b1);
            end else begin
               case (mode_reg)
                  sga_pkg::MODE_MIN: begin
                     if (first || s < acc) acc = 24'(s);
                  end
                  sga_pkg::MODE_MAX: begin
                     if (first || s > acc) acc = 24'(s);
                  end
                  sga_pkg::MODE_PROD: begin
                     if (first) begin
                        acc = 24'(s);
                     end else begin
                        wide = 64'(acc);
                        wide = (wide * 64'(s)) >> 16;
                        acc = cap_acc(wide);
                     end
                     if (acc == 0) begin
                        settle_group(invert_reg ? sga_pkg::SCORE_ONE : 17'd0, 1'b0);
                     end
                  end
                  sga_pkg::MODE_FNZ: begin
                     if (s != 0) begin
                        settle_group(invert_reg ? sga_pkg::SCORE_ONE - s : s, 1'b0);
                     end
                  end
                  default: begin
                     // Sum, mean and the unused codes all accumulate.
                     wide = 64'(acc);
                     acc = cap_acc(wide + 64'(s));
                  end
               endcase
            end
         end
         // Skipped and ignored children still count toward the position.
         if (position < MAX_CHILDREN) position++;
         if (last) begin
            if (settled) begin
               r.score = {6'd0, settled_score};
               r.vetoed = settled_veto;
            end else begin
               v = longint'(acc);
               if (mode_reg == sga_pkg::MODE_MEAN && position != 0) v = v / position;
               if (invert_reg) v = 65536 - v;
               if (v > SCORE_HI) v = SCORE_HI;
               if (v < SCORE_LO) v = SCORE_LO;
               r.score = v[22:0];
               r.vetoed = 1'b0;
            end
            group_results_q.push_back(r);
            clear_group_state();
         end
      end
   endtask

   // Offers one child and returns at the edge where it is taken, leaving valid
   // high so that a following child can go out back to back.
   task automatic push_child(input logic [16:0] score, input bit counted, input bit veto,
                             input bit last, input bit empty);
      int gap;
      if (!steady_sender && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, score};
      req_tuser <= {empty, veto, counted};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      fold_child(score, counted, veto, last, empty);
   endtask

   // Holds the sender off until every owed result has arrived and the block
   // has had time to finish any group work that produces no result.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (group_results_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers while the block is quiet. Unused upper bits of the
   // invert write carry junk, which the block must drop.
   task automatic program_aggregator(input logic [2:0] mode, input logic invert);
      logic [1:0] junk;
      junk = 2'($urandom_range(0, 3));
      wait_for_results();
      csr_wen <= 1'b1;
      csr_index <= sga_pkg::CSR_EVAL_MODE;
      csr_wdata <= mode;
      @(posedge clock);
      csr_index <= sga_pkg::CSR_INVERT;
      csr_wdata <= {junk, invert};
      @(posedge clock);
      csr_wen <= 1'b0;
      mode_reg = mode;
      invert_reg = invert;
   endtask

   function automatic logic [16:0] pick_score(input score_mix_type mix);
      logic [16:0] s;
      case ($urandom_range(0, 9))
         0: s = 17'd0;
         1: s = sga_pkg::SCORE_ONE;
         2: s = 17'($urandom_range(65537, 131071));
         default: begin
            case (mix)
               SCORES_HIGH: s = 17'($urandom_range(49152, 65536));
               SCORES_LOW:  s = 17'($urandom_range(0, 4095));
               default:     s = 17'($urandom_range(0, 65536));
            endcase
         end
      endcase
      return s;
   endfunction

   // Out of reset the block multiplies without invert. The first score is
   // above one and must be taken as one.
   task automatic test_reset_defaults();
      push_child(17'h1FFFF, 1'b1, 1'b0, 1'b0, 1'b0);
      push_child(17'd32768, 1'b1, 1'b0, 1'b1, 1'b0);
   endtask

   // Every code of eval_mode on the same two children, zero then 50000, with
   // invert toggling so that both extremes of the register pair are seen.
   task automatic test_each_mode();
      logic [2:0] mode;
      for (int m = 0; m < 8; m++) begin
         mode = 3'(m);
         program_aggregator(mode, mode[0]);
         push_child(17'd0, 1'b1, 1'b0, 1'b0, 1'b0);
         push_child(17'd50000, 1'b1, 1'b0, 1'b1, 1'b0);
      end
   endtask

   task automatic test_special_cases();
      // A veto wins over invert, and the children after it are ignored.
      program_aggregator(sga_pkg::MODE_MAX, 1'b1);
      push_child(17'd30000, 1'b1, 1'b0, 1'b0, 1'b0);
      push_child(17'd0, 1'b1, 1'b1, 1'b0, 1'b0);
      push_child(sga_pkg::SCORE_ONE, 1'b1, 1'b0, 1'b1, 1'b0);
      // An empty group answers zero whatever else the transfer carries.
      push_child(17'h1ABCD, 1'b1, 1'b1, 1'b1, 1'b1);
      // A skipped first child leaves the product seeded with zero.
      program_aggregator(sga_pkg::MODE_PROD, 1'b0);
      push_child(17'd40000, 1'b0, 1'b0, 1'b0, 1'b0);
      push_child(17'd40000, 1'b1, 1'b0, 1'b1, 1'b0);
      // A product that truncates to zero ends the group with one when inverted.
      program_aggregator(sga_pkg::MODE_PROD, 1'b1);
      push_child(17'd3, 1'b1, 1'b0, 1'b0, 1'b0);
      push_child(17'd3, 1'b1, 1'b0, 1'b1, 1'b0);
      // First-nonzero that never finds a score falls back to an inverted zero.
      program_aggregator(sga_pkg::MODE_FNZ, 1'b1);
      push_child(17'd0, 1'b1, 1'b0, 1'b0, 1'b0);
      push_child(17'd0, 1'b1, 1'b0, 1'b1, 1'b0);
      // Switching to mean inside a group divides the running sum at the end.
      program_aggregator(sga_pkg::MODE_SUM, 1'b0);
      push_child(17'd20000, 1'b1, 1'b0, 1'b0, 1'b0);
      push_child(17'd40000, 1'b1, 1'b0, 1'b0, 1'b0);
      program_aggregator(sga_pkg::MODE_MEAN, 1'b0);
      push_child(17'd30000, 1'b1, 1'b0, 1'b1, 1'b0);
   endtask

   // One well-formed group with random content. Now and then an empty-group
   // flag or a stray last flag breaks it up, as noise. Long groups of high
   // scores drive the position and the sum into saturation.
   task automatic send_random_group(output int sent);
      int            len;
      bit            long_group;
      score_mix_type mix;
      bit            counted;
      bit            veto;
      bit            last;
      bit            empty;
      long_group = ($urandom_range(0, 9) == 0);
      len = long_group ? $urandom_range(66, 90) : $urandom_range(1, 8);
      if (long_group && $urandom_range(0, 2) != 0) mix = SCORES_HIGH;
      else mix = score_mix_type'($urandom_range(0, 2));
      for (int i = 0; i < len; i++) begin
         counted = long_group ? ($urandom_range(0, 29) != 0) : ($urandom_range(0, 6) != 0);
         veto = long_group ? ($urandom_range(0, 199) == 0) : ($urandom_range(0, 39) == 0);
         empty = ($urandom_range(0, 49) == 0);
         last = (i == len - 1) || ($urandom_range(0, 59) == 0);
         push_child(pick_score(mix), counted, veto, last, empty);
      end
      sent = len;
   endtask

   // Phases walk through every mode, then random settings. Some phases keep
   // the sender steady, and now and then it waits for all results first.
   task automatic test_random_groups();
      logic [2:0] mode;
      logic       invert;
      int         items;
      int         sent;
      for (int phase = 0; phase < 10; phase++) begin
         mode = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
         invert = (phase < 8) ? phase[1] : 1'($urandom_range(0, 1));
         program_aggregator(mode, invert);
         steady_sender = (phase % 4 == 2);
         items = 0;
         while (items < 38) begin
            send_random_group(sent);
            items += sent;
            if ($urandom_range(0, 7) == 0) wait_for_results();
         end
      end
      steady_sender = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_each_mode();
      test_special_cases();
      test_random_groups();
      wait_for_results();
      if (err_count == 0) begin
         $display("tb_score_group_aggregator_core: clean");
      end else begin
         $display("tb_score_group_aggregator_core: errors");
      end
      $finish;
   end

endmodule
